[design/esc_pkg.sv]
// shared constants, types and month table for the epoch to calendar unit
package esc_pkg;

    // seconds at 2000-01-01 and 2100-01-01
    localparam logic [31:0] EPOCH_2000 = 32'd946684800;
    localparam logic [31:0] EPOCH_2100 = 32'd4102444800;

    // seconds per day is 128 * 675: divide by 675 with floor(2^35 / 675)
    localparam logic [9:0]  DAY_DIV    = 10'd675;
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;

    // days per four-year block, floor(2^26 / 1461)
    localparam logic [10:0] QUAD_DAYS  = 11'd1461;
    localparam logic [15:0] QUAD_RECIP = 16'd45933;

    // seconds per hour is 16 * 225: floor(2^20 / 225)
    localparam logic [7:0]  HOUR_DIV   = 8'd225;
    localparam logic [12:0] HOUR_RECIP = 13'd4660;

    // seconds per minute is 4 * 15: floor(2^16 / 15)
    localparam logic [3:0]  MIN_DIV    = 4'd15;
    localparam logic [12:0] MIN_RECIP  = 13'd4369;

    // first day of each year within a four-year block (first year is leap)
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    // day of year on which each month starts, common year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [6:0] year_offset;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
    } t_date;

    // start day of month m (1..12), one later from march on in a leap year
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        logic [8:0] base;
        idx  = m - 4'd1;
        base = (idx > 4'd11) ? 9'd0 : MONTH_START[idx];
        if (leap && (m >= 4'd3)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

[design/esc_date_split.sv]
// day count since 2000-01-01 to year, month and day, five register stages
module esc_date_split (
    input  logic             i_clk,
    input  logic             i_adv,
    input  logic [15:0]      i_days,
    output esc_pkg::t_date   o_date
);

    // stage 5: quotient estimate product
    logic [31:0] r_s5_p;
    logic [15:0] r_s5_d;
    // stage 6: estimate and back product
    logic [5:0]  r_s6_q;
    logic [16:0] r_s6_prod;
    logic [15:0] r_s6_d;
    // stage 7: four-year block and day within it
    logic [5:0]  r_s7_quad;
    logic [10:0] r_s7_dq;
    // stage 8: year within block, day of year
    logic [5:0]  r_s8_quad;
    logic [1:0]  r_s8_yiq;
    logic [8:0]  r_s8_doy;
    logic        r_s8_leap;
    // stage 9: month found
    logic [6:0]  r_s9_year;
    logic [3:0]  r_s9_month;
    logic [8:0]  r_s9_doy;
    logic        r_s9_leap;

    logic [5:0]  n_q;
    logic [16:0] n_diff;
    logic [5:0]  n_quad;
    logic [10:0] n_dq;
    logic [1:0]  n_yiq;
    logic [10:0] n_doy_w;
    logic [3:0]  n_month;
    logic [8:0]  n_day_w;

    always_comb begin
        n_q    = r_s5_p[31:26];
        n_diff = {1'b0, r_s6_d} - r_s6_prod;
        if (n_diff[11:0] >= {1'b0, esc_pkg::QUAD_DAYS}) begin
            n_quad = r_s6_q + 6'd1;
            n_dq   = 11'(n_diff[11:0] - {1'b0, esc_pkg::QUAD_DAYS});
        end else begin
            n_quad = r_s6_q;
            n_dq   = n_diff[10:0];
        end
    end

    always_comb begin
        if (r_s7_dq < esc_pkg::YEAR1_START) begin
            n_yiq   = 2'd0;
            n_doy_w = r_s7_dq;
        end else if (r_s7_dq < esc_pkg::YEAR2_START) begin
            n_yiq   = 2'd1;
            n_doy_w = r_s7_dq - esc_pkg::YEAR1_START;
        end else if (r_s7_dq < esc_pkg::YEAR3_START) begin
            n_yiq   = 2'd2;
            n_doy_w = r_s7_dq - esc_pkg::YEAR2_START;
        end else begin
            n_yiq   = 2'd3;
            n_doy_w = r_s7_dq - esc_pkg::YEAR3_START;
        end
    end

    // last month whose first day is not after the day of year
    always_comb begin
        n_month = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r_s8_doy >= esc_pkg::month_start(4'(k), r_s8_leap)) begin
                n_month = 4'(k);
            end
        end
    end

    always_comb begin
        n_day_w = r_s9_doy - esc_pkg::month_start(r_s9_month, r_s9_leap) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s5_p     <= 32'(i_days) * 32'(esc_pkg::QUAD_RECIP);
            r_s5_d     <= i_days;
            r_s6_q     <= n_q;
            r_s6_prod  <= 17'(n_q) * 17'(esc_pkg::QUAD_DAYS);
            r_s6_d     <= r_s5_d;
            r_s7_quad  <= n_quad;
            r_s7_dq    <= n_dq;
            r_s8_quad  <= r_s7_quad;
            r_s8_yiq   <= n_yiq;
            r_s8_doy   <= n_doy_w[8:0];
            r_s8_leap  <= (n_yiq == 2'd0);
            r_s9_year  <= 7'({r_s8_quad, 2'b00} + {6'd0, r_s8_yiq});
            r_s9_month <= n_month;
            r_s9_doy   <= r_s8_doy;
            r_s9_leap  <= r_s8_leap;
        end
    end

    assign o_date.year_offset  = r_s9_year;
    assign o_date.month_number = r_s9_month;
    assign o_date.day_of_month = n_day_w[4:0];

endmodule

[design/epoch_seconds_to_calendar_unit.sv]
// unix seconds to utc calendar date and time of day, ten-stage pipeline
// throughput: one item per cycle, limited by nothing but output stall
// a stall at the output freezes every stage at once, so nothing is lost
// reset (synchronous, active low) clears the stage valid bits only
// divisions by constants use reciprocal multiplies with one correction step
module epoch_seconds_to_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_year_offset,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour_of_day,
    output logic [5:0]  o_minute_of_hour,
    output logic [5:0]  o_second_of_minute,
    output logic        o_in_range
);

    // one valid bit per stage, stage ten is the output register
    logic [9:0]  r_vld;
    logic [9:0]  n_vld;
    logic        w_adv;

    // stage 1: seconds since 2000 and range flag
    logic [31:0] r_s1_t;
    logic        r_s1_inr;
    // stage 2: day quotient estimate product (upper bits over 675)
    logic [50:0] r_s2_p;
    logic [24:0] r_s2_x;
    logic [6:0]  r_s2_lo7;
    logic        r_s2_inr;
    // stage 3: estimate and its back product
    logic [15:0] r_s3_q;
    logic [25:0] r_s3_prod;
    logic [24:0] r_s3_x;
    logic [6:0]  r_s3_lo7;
    logic        r_s3_inr;
    // stage 4: day count and second of day
    logic [15:0] r_s4_days;
    logic [16:0] r_s4_sod;
    logic        r_s4_inr;
    // stage 5: hour estimate product
    logic [24:0] r_s5_p;
    logic [12:0] r_s5_y;
    logic [3:0]  r_s5_lo4;
    logic        r_s5_inr;
    // stage 6: hour estimate and back product
    logic [4:0]  r_s6_q;
    logic [12:0] r_s6_prod;
    logic [12:0] r_s6_y;
    logic [3:0]  r_s6_lo4;
    logic        r_s6_inr;
    // stage 7: hour and second of hour
    logic [4:0]  r_s7_hour;
    logic [11:0] r_s7_soh;
    logic        r_s7_inr;
    // stage 8: minute estimate product
    logic [21:0] r_s8_p;
    logic [9:0]  r_s8_z;
    logic [1:0]  r_s8_lo2;
    logic [4:0]  r_s8_hour;
    logic        r_s8_inr;
    // stage 9: minute estimate and back product
    logic [5:0]  r_s9_q;
    logic [9:0]  r_s9_prod;
    logic [9:0]  r_s9_z;
    logic [1:0]  r_s9_lo2;
    logic [4:0]  r_s9_hour;
    logic        r_s9_inr;
    // stage 10: output register
    logic [6:0]  r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic        r_inr;

    logic        n_inr;
    logic [15:0] n_q_day;
    logic [25:0] n_diff_day;
    logic [15:0] n_days;
    logic [9:0]  n_rem_day;
    logic [4:0]  n_q_hour;
    logic [12:0] n_diff_hour;
    logic [4:0]  n_hour;
    logic [7:0]  n_rem_hour;
    logic [5:0]  n_q_min;
    logic [9:0]  n_diff_min;
    logic [5:0]  n_minute;
    logic [3:0]  n_rem_min;

    esc_pkg::t_date w_date;

    // the whole pipe moves unless a finished item is held at the output
    assign w_adv   = !r_vld[9] || !i_stall;
    assign o_stall = !w_adv;
    assign n_vld   = {r_vld[8:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    assign n_inr = (i_epoch_seconds >= esc_pkg::EPOCH_2000) &&
                   (i_epoch_seconds <  esc_pkg::EPOCH_2100);

    // day split: estimate is exact or one short, fix with one compare
    always_comb begin
        n_q_day    = r_s2_p[50:35];
        n_diff_day = {1'b0, r_s3_x} - r_s3_prod;
        if (n_diff_day[10:0] >= {1'b0, esc_pkg::DAY_DIV}) begin
            n_days    = r_s3_q + 16'd1;
            n_rem_day = 10'(n_diff_day[10:0] - {1'b0, esc_pkg::DAY_DIV});
        end else begin
            n_days    = r_s3_q;
            n_rem_day = n_diff_day[9:0];
        end
    end

    // hour split
    always_comb begin
        n_q_hour    = r_s5_p[24:20];
        n_diff_hour = r_s6_y - r_s6_prod;
        if (n_diff_hour[8:0] >= {1'b0, esc_pkg::HOUR_DIV}) begin
            n_hour     = r_s6_q + 5'd1;
            n_rem_hour = 8'(n_diff_hour[8:0] - {1'b0, esc_pkg::HOUR_DIV});
        end else begin
            n_hour     = r_s6_q;
            n_rem_hour = n_diff_hour[7:0];
        end
    end

    // minute split
    always_comb begin
        n_q_min    = r_s8_p[21:16];
        n_diff_min = r_s9_z - r_s9_prod;
        if (n_diff_min[4:0] >= {1'b0, esc_pkg::MIN_DIV}) begin
            n_minute  = r_s9_q + 6'd1;
            n_rem_min = 4'(n_diff_min[4:0] - {1'b0, esc_pkg::MIN_DIV});
        end else begin
            n_minute  = r_s9_q;
            n_rem_min = n_diff_min[3:0];
        end
    end

    // day count to year, month and day runs alongside stages five to ten
    esc_date_split u_date (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_days (r_s4_days),
        .o_date (w_date)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_t    <= i_epoch_seconds - esc_pkg::EPOCH_2000;
            r_s1_inr  <= n_inr;

            r_s2_p    <= 51'(r_s1_t[31:7]) * 51'(esc_pkg::DAY_RECIP);
            r_s2_x    <= r_s1_t[31:7];
            r_s2_lo7  <= r_s1_t[6:0];
            r_s2_inr  <= r_s1_inr;

            r_s3_q    <= n_q_day;
            r_s3_prod <= 26'(n_q_day) * 26'(esc_pkg::DAY_DIV);
            r_s3_x    <= r_s2_x;
            r_s3_lo7  <= r_s2_lo7;
            r_s3_inr  <= r_s2_inr;

            r_s4_days <= n_days;
            r_s4_sod  <= {n_rem_day, r_s3_lo7};
            r_s4_inr  <= r_s3_inr;

            r_s5_p    <= 25'(r_s4_sod[16:4]) * 25'(esc_pkg::HOUR_RECIP);
            r_s5_y    <= r_s4_sod[16:4];
            r_s5_lo4  <= r_s4_sod[3:0];
            r_s5_inr  <= r_s4_inr;

            r_s6_q    <= n_q_hour;
            r_s6_prod <= 13'(n_q_hour) * 13'(esc_pkg::HOUR_DIV);
            r_s6_y    <= r_s5_y;
            r_s6_lo4  <= r_s5_lo4;
            r_s6_inr  <= r_s5_inr;

            r_s7_hour <= n_hour;
            r_s7_soh  <= {n_rem_hour, r_s6_lo4};
            r_s7_inr  <= r_s6_inr;

            r_s8_p    <= 22'(r_s7_soh[11:2]) * 22'(esc_pkg::MIN_RECIP);
            r_s8_z    <= r_s7_soh[11:2];
            r_s8_lo2  <= r_s7_soh[1:0];
            r_s8_hour <= r_s7_hour;
            r_s8_inr  <= r_s7_inr;

            r_s9_q    <= n_q_min;
            r_s9_prod <= 10'(n_q_min) * 10'(esc_pkg::MIN_DIV);
            r_s9_z    <= r_s8_z;
            r_s9_lo2  <= r_s8_lo2;
            r_s9_hour <= r_s8_hour;
            r_s9_inr  <= r_s8_inr;

            // out of range gives all zero fields
            if (r_s9_inr) begin
                r_year   <= w_date.year_offset;
                r_month  <= w_date.month_number;
                r_day    <= w_date.day_of_month;
                r_hour   <= r_s9_hour;
                r_minute <= n_minute;
                r_second <= {n_rem_min, r_s9_lo2};
            end else begin
                r_year   <= '0;
                r_month  <= '0;
                r_day    <= '0;
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
            end
            r_inr <= r_s9_inr;
        end
    end

    assign o_valid            = r_vld[9];
    assign o_year_offset      = r_year;
    assign o_month_number     = r_month;
    assign o_day_of_month     = r_day;
    assign o_hour_of_day      = r_hour;
    assign o_minute_of_hour   = r_minute;
    assign o_second_of_minute = r_second;
    assign o_in_range         = r_inr;

endmodule

[design/esc_checker.sv]
// port-level checks for the epoch to calendar unit, bound to the top level
module esc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_epoch_seconds,
    input logic        o_valid,
    input logic        i_stall,
    input logic [6:0]  o_year_offset,
    input logic [3:0]  o_month_number,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour_of_day,
    input logic [5:0]  o_minute_of_hour,
    input logic [5:0]  o_second_of_minute,
    input logic        o_in_range
);

    // an out-of-range item carries only zeros
    a_zero_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |->
            (o_year_offset == 7'd0) && (o_month_number == 4'd0) &&
            (o_day_of_month == 5'd0) && (o_hour_of_day == 5'd0) &&
            (o_minute_of_hour == 6'd0) && (o_second_of_minute == 6'd0))
        else $error("out-of-range item has non-zero fields");

    // an in-range item is a real date and time
    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_range) |->
            (o_year_offset <= 7'd99) &&
            (o_month_number >= 4'd1) && (o_month_number <= 4'd12) &&
            (o_day_of_month >= 5'd1) && (o_hour_of_day <= 5'd23) &&
            (o_minute_of_hour <= 6'd59) && (o_second_of_minute <= 6'd59))
        else $error("in-range item has an illegal field");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_year_offset) && $stable(o_month_number) &&
             $stable(o_day_of_month) && $stable(o_hour_of_day) &&
             $stable(o_minute_of_hour) && $stable(o_second_of_minute) &&
             $stable(o_in_range)))
        else $error("held item changed");

    // the pipe only pushes back when the output is held
    a_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (.*);

[bench/testbench.sv]
// self-checking testbench for the unix seconds to calendar date and time unit
`timescale 1ns / 1ps

module testbench;

    // seconds in the units the conversion strips off, largest first
    localparam int unsigned LEAP_YEAR_SECONDS   = 31622400;
    localparam int unsigned COMMON_YEAR_SECONDS = 31536000;
    localparam int unsigned DAY_SECONDS         = 86400;
    localparam int unsigned HOUR_SECONDS        = 3600;
    localparam int unsigned MINUTE_SECONDS      = 60;

    // far beyond the slowest legal run, including the long output hold-off
    localparam int CYCLE_LIMIT = 300000;

    // one converted date and time as the unit presents it
    typedef struct packed {
        logic [6:0] year_offset;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
        logic       in_range;
    } t_calendar;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic        i_stall;
    logic [6:0]  o_year_offset;
    logic [3:0]  o_month_number;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour_of_day;
    logic [5:0]  o_minute_of_hour;
    logic [5:0]  o_second_of_minute;
    logic        o_in_range;

    // dates still owed by the unit, oldest first
    t_calendar   expected_dates[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // idle chances per cycle, in percent, for each side
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // length of a long output hold-off, picked up by the stall process
    int unsigned hold_request = 0;

    epoch_seconds_to_calendar_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_year_offset      (o_year_offset),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute),
        .o_in_range         (o_in_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // calendar arithmetic
    // ---------------------------------------------------------------

    // gregorian rule: every fourth year, but not centuries unless by 400
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned year_seconds(input int unsigned yr);
        return is_leap(yr) ? LEAP_YEAR_SECONDS : COMMON_YEAR_SECONDS;
    endfunction

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
        case (mon)
            2: begin
                return is_leap(yr) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    // the date and time the unit owes for a given count of seconds
    function automatic t_calendar predict_calendar(input logic [31:0] secs);
        t_calendar   cal;
        int unsigned rest;
        int unsigned yr;
        int unsigned mon;
        cal = '0;
        // outside the supported century everything reads as zero
        if (secs < esc_pkg::EPOCH_2000 || secs >= esc_pkg::EPOCH_2100) begin
            return cal;
        end
        rest = secs - esc_pkg::EPOCH_2000;
        yr   = 2000;
        mon  = 1;
        // strip whole years, then whole months; the last year and month absorb the rest
        while (rest >= year_seconds(yr) && yr < 2099) begin
            rest -= year_seconds(yr);
            yr++;
        end
        while (rest >= month_length(yr, mon) * DAY_SECONDS && mon < 12) begin
            rest -= month_length(yr, mon) * DAY_SECONDS;
            mon++;
        end
        cal.year_offset      = 7'(yr - 2000);
        cal.month_number     = 4'(mon);
        cal.day_of_month     = 5'(1 + rest / DAY_SECONDS);
        rest                 = rest % DAY_SECONDS;
        cal.hour_of_day      = 5'(rest / HOUR_SECONDS);
        rest                 = rest % HOUR_SECONDS;
        cal.minute_of_hour   = 6'(rest / MINUTE_SECONDS);
        cal.second_of_minute = 6'(rest % MINUTE_SECONDS);
        cal.in_range         = 1'b1;
        return cal;
    endfunction

    // seconds since 1970 for a date and time within 2000..2099
    function automatic logic [31:0] date_to_epoch(input int unsigned yr, input int unsigned mon,
                                                  input int unsigned day, input int unsigned hr,
                                                  input int unsigned mn, input int unsigned sc);
        logic [31:0] secs;
        int unsigned y;
        int unsigned m;
        secs = esc_pkg::EPOCH_2000;
        for (y = 2000; y < yr; y++) begin
            secs += year_seconds(y);
        end
        for (m = 1; m < mon; m++) begin
            secs += month_length(yr, m) * DAY_SECONDS;
        end
        secs += (day - 1) * DAY_SECONDS + hr * HOUR_SECONDS + mn * MINUTE_SECONDS + sc;
        return secs;
    endfunction

    // random timestamp: any 32-bit value, any in-range value, a month edge or a range edge
    function automatic logic [31:0] pick_epoch();
        int unsigned choice;
        int unsigned yr;
        int unsigned mon;
        logic [31:0] secs;
        choice = $urandom_range(9);
        if (choice < 4) begin
            return $urandom();
        end
        if (choice < 8) begin
            return esc_pkg::EPOCH_2000 +
                   $urandom_range(esc_pkg::EPOCH_2100 - esc_pkg::EPOCH_2000 - 1);
        end
        if (choice == 8) begin
            // a few seconds either side of the start or end of a month
            yr  = 2000 + $urandom_range(99);
            mon = $urandom_range(1, 12);
            if ($urandom_range(1) == 0) begin
                secs = date_to_epoch(yr, mon, 1, 0, 0, 0);
            end else begin
                secs = date_to_epoch(yr, mon, month_length(yr, mon), 23, 59, 59);
            end
            return secs + $urandom_range(6) - 3;
        end
        // close to either end of the supported century
        if ($urandom_range(1) == 0) begin
            return esc_pkg::EPOCH_2000 + $urandom_range(400000) - 200000;
        end
        return esc_pkg::EPOCH_2100 + $urandom_range(400000) - 200000;
    endfunction

    // ---------------------------------------------------------------
    // handshake helpers
    // ---------------------------------------------------------------

    // offer one item, hold it until taken, then maybe idle a while
    task automatic send_item(input logic [31:0] secs);
        int unsigned gap;
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (o_stall);
        expected_dates.push_back(predict_calendar(secs));
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) begin
            gap++;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid once a burst is over
    task automatic idle_sender();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_dates.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // extremes of the input and both edges of the supported century
    task automatic test_range_edges();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(32'h0000_0000);
        send_item(esc_pkg::EPOCH_2000 - 1);
        send_item(esc_pkg::EPOCH_2000);
        send_item(32'h7FFF_FFFF);
        send_item(32'h8000_0000);
        send_item(esc_pkg::EPOCH_2100 - 1);
        send_item(esc_pkg::EPOCH_2100);
        send_item(32'hFFFF_FFFF);
        idle_sender();
        wait_drained();
    endtask

    // leap days, month and year ends, last second of the day
    task automatic test_calendar_edges();
        send_item(date_to_epoch(2000, 2, 28, 23, 59, 59));
        send_item(date_to_epoch(2000, 2, 29, 12, 34, 56));
        send_item(date_to_epoch(2000, 3, 1, 0, 0, 0));
        send_item(date_to_epoch(2000, 12, 31, 23, 59, 59));
        send_item(date_to_epoch(2001, 2, 28, 23, 59, 59));
        send_item(date_to_epoch(2001, 3, 1, 0, 0, 0));
        send_item(date_to_epoch(2024, 12, 31, 23, 59, 59));
        send_item(date_to_epoch(2050, 6, 30, 23, 59, 59));
        send_item(date_to_epoch(2050, 7, 1, 0, 0, 0));
        send_item(date_to_epoch(2096, 2, 29, 23, 59, 59));
        send_item(date_to_epoch(2099, 12, 31, 0, 0, 0));
        idle_sender();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int unsigned send_pct,
                                       input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            send_item(pick_epoch());
        end
        idle_sender();
        wait_drained();
    endtask

    // long output hold-off while items keep coming, so the pipeline fills and stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 400;
        repeat (40) begin
            send_item(pick_epoch());
        end
        idle_sender();
        wait_drained();
    endtask

    // short bursts, each fully drained before the next begins
    task automatic test_paused_sender();
        send_idle_pct = 0;
        recv_idle_pct = 30;
        repeat (4) begin
            repeat (12) begin
                send_item(pick_epoch());
            end
            idle_sender();
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // output stall: random, or held high for a requested stretch
    // ---------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic check_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field_name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_calendar want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_dates.size() == 0) begin
                $error("result item arrived with nothing outstanding");
                mismatch_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("year_offset", 32'(want.year_offset), 32'(o_year_offset));
                check_field("month_number", 32'(want.month_number), 32'(o_month_number));
                check_field("day_of_month", 32'(want.day_of_month), 32'(o_day_of_month));
                check_field("hour_of_day", 32'(want.hour_of_day), 32'(o_hour_of_day));
                check_field("minute_of_hour", 32'(want.minute_of_hour),
                            32'(o_minute_of_hour));
                check_field("second_of_minute", 32'(want.second_of_minute),
                            32'(o_second_of_minute));
                check_field("in_range", 32'(want.in_range), 32'(o_in_range));
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_epoch_seconds = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_range_edges();
        test_calendar_edges();
        // sender idles lightly, receiver heavily, then the reverse, then flat out
        test_random_traffic(480, 14, 47);
        test_random_traffic(480, 47, 14);
        test_backpressure();
        test_paused_sender();
        test_random_traffic(480, 0, 0);

        // let any stray result show up after the pipeline depth
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
design/esc_pkg.sv
design/esc_date_split.sv
design/epoch_seconds_to_calendar_unit.sv
design/esc_checker.sv
bench/testbench.sv
